// File: rtl/lpps_pkg.sv
// Shared types, codes and pattern decoders for the line position PID steering block.
package lpps_pkg;

  localparam int unsigned SENSOR_WIDTH = 8;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 8;
  localparam int unsigned ERR_W        = 9;
  localparam int unsigned SPEED_W      = 10;
  localparam int unsigned WSUM_W       = 7;
  localparam int unsigned CNT_W        = 4;
  localparam int unsigned ACC_W        = 20;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_OFFSET  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_OFFSET = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LOST_ERROR   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_MODE     = 3'd7;

  // drive modes
  localparam logic [1:0] MODE_FWD  = 2'd0;
  localparam logic [1:0] MODE_CCW  = 2'd1;
  localparam logic [1:0] MODE_CW   = 2'd2;
  localparam logic [1:0] MODE_STOP = 2'd3;

  // remembered edge
  localparam logic [1:0] EDGE_NONE  = 2'd0;
  localparam logic [1:0] EDGE_LEFT  = 2'd1;
  localparam logic [1:0] EDGE_RIGHT = 2'd2;

  // multiplier operand select
  localparam logic [1:0] SEL_P = 2'd0;
  localparam logic [1:0] SEL_I = 2'd1;
  localparam logic [1:0] SEL_D = 2'd2;

  localparam logic [SENSOR_WIDTH-1:0] FULL_LINE = 8'hFF;
  localparam logic [SENSOR_WIDTH-1:0] MID_MASK  = 8'h7E;

  localparam logic signed [ERR_W:0] SUM_MAX = 10'sd200;
  localparam logic signed [ERR_W:0] SUM_MIN = -10'sd200;
  localparam logic signed [ACC_W-1:0] PID_MAX = 20'sd150;
  localparam logic signed [ACC_W-1:0] PID_MIN = -20'sd150;

  typedef struct packed {
    logic [7:0] gain_p;
    logic [7:0] gain_i;
    logic [7:0] gain_d;
    logic [7:0] base_speed;
    logic [7:0] left_offset;
    logic [7:0] right_offset;
    logic [7:0] lost_error;
    logic       gap_mode;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic       div_step;
    logic       err_en;
    logic       sum_en;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       commit;
  } cmd_t;

  typedef struct packed {
    logic hold;
    logic out_free;
  } sts_t;

  function automatic logic is_white(input logic [SENSOR_WIDTH-1:0] v);
    unique case (v) inside
      8'h60, 8'h70, 8'h20, 8'h30, 8'h38, 8'h10, 8'h18,
      8'h1C, 8'h08, 8'h0C, 8'h0E, 8'h04, 8'h06: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic is_black(input logic [SENSOR_WIDTH-1:0] v);
    unique case (v) inside
      8'h9F, 8'h8F, 8'hDF, 8'hCF, 8'hC7, 8'hEF, 8'hE7,
      8'hE3, 8'hF7, 8'hF3, 8'hF1, 8'hFB, 8'hF9: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic is_online(input logic [SENSOR_WIDTH-1:0] v);
    unique case (v) inside
      8'h60, 8'h70, 8'h30, 8'h38, 8'h18, 8'h1C, 8'h0C, 8'h0E, 8'h06,
      8'h9F, 8'h8F, 8'hCF, 8'hC7, 8'hE7, 8'hE3, 8'hF3, 8'hF1, 8'hF9: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

endpackage

// File: rtl/lpps_in_if.sv
// Sensor sample channel.
interface lpps_in_if;
  logic                            valid;
  logic                            ready;
  logic [lpps_pkg::SENSOR_WIDTH-1:0] sensor_bits;

  modport source (output valid, output sensor_bits, input ready);
  modport sink (input valid, input sensor_bits, output ready);
endinterface

// File: rtl/lpps_out_if.sv
// Steering result channel.
interface lpps_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [lpps_pkg::ERR_W-1:0]   position_error;
  logic signed [lpps_pkg::ERR_W-1:0]   pid_output;
  logic signed [lpps_pkg::SPEED_W-1:0] left_speed;
  logic signed [lpps_pkg::SPEED_W-1:0] right_speed;
  logic [1:0]                         drive_mode;
  logic                               indicator;
  logic                               white_line_track;

  modport source (output valid, output position_error, output pid_output,
                  output left_speed, output right_speed, output drive_mode,
                  output indicator, output white_line_track, input ready);
  modport sink (input valid, input position_error, input pid_output,
                input left_speed, input right_speed, input drive_mode,
                input indicator, input white_line_track, output ready);
endinterface

// File: rtl/lpps_regs.sv
// Configuration register file.
module lpps_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            we_i,
  input  logic [lpps_pkg::CFG_IDX_W-1:0]  idx_i,
  input  logic [lpps_pkg::CFG_DATA_W-1:0] data_i,
  output lpps_pkg::cfg_t                  cfg_o
);
  import lpps_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (idx_i)
        REG_GAIN_P:       cfg_d.gain_p       = data_i;
        REG_GAIN_I:       cfg_d.gain_i       = data_i;
        REG_GAIN_D:       cfg_d.gain_d       = data_i;
        REG_BASE_SPEED:   cfg_d.base_speed   = data_i;
        REG_LEFT_OFFSET:  cfg_d.left_offset  = data_i;
        REG_RIGHT_OFFSET: cfg_d.right_offset = data_i;
        REG_LOST_ERROR:   cfg_d.lost_error   = data_i;
        REG_GAP_MODE:     cfg_d.gap_mode     = data_i[0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p       <= 8'd10;
      cfg_q.gain_i       <= 8'd0;
      cfg_q.gain_d       <= 8'd0;
      cfg_q.base_speed   <= 8'd150;
      cfg_q.left_offset  <= 8'd50;
      cfg_q.right_offset <= 8'd50;
      cfg_q.lost_error   <= 8'd100;
      cfg_q.gap_mode     <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/lpps_ctrl.sv
// Sequencer: walks one sample through divide, error, sum, multiply and commit.
module lpps_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lpps_pkg::sts_t sts_i,
  output lpps_pkg::cmd_t cmd_o
);
  import lpps_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_ERR  = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam logic [2:0] DIV_LAST = 3'(WSUM_W - 1);
  localparam logic [2:0] MUL_LAST = 3'd2;

  logic [2:0] state_q, state_d;
  logic [2:0] step_q, step_d;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.hold) begin
          state_d = S_DONE;
        end else begin
          cmd_o.div_step = 1'b1;
          step_d         = step_q + 3'd1;
          if (step_q == DIV_LAST) state_d = S_ERR;
        end
      end
      S_ERR: begin
        cmd_o.err_en = 1'b1;
        state_d      = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum_en = 1'b1;
        step_d       = '0;
        state_d      = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        unique case (step_q[1:0])
          2'd0:    cmd_o.mul_sel = SEL_P;
          2'd1:    cmd_o.mul_sel = SEL_I;
          default: cmd_o.mul_sel = SEL_D;
        endcase
        step_d = step_q + 3'd1;
        if (step_q == MUL_LAST) state_d = S_DONE;
      end
      S_DONE: begin
        // hold until the result register can take the beat
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

// File: rtl/lpps_dp.sv
// Datapath: polarity, centroid divider, PID multiply-accumulate, result register.
module lpps_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lpps_pkg::cfg_t                      cfg_i,
  input  lpps_pkg::cmd_t                      cmd_i,
  output lpps_pkg::sts_t                      sts_o,
  input  logic [lpps_pkg::SENSOR_WIDTH-1:0]   sensor_bits_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic signed [lpps_pkg::ERR_W-1:0]   position_error_o,
  output logic signed [lpps_pkg::ERR_W-1:0]   pid_output_o,
  output logic signed [lpps_pkg::SPEED_W-1:0] left_speed_o,
  output logic signed [lpps_pkg::SPEED_W-1:0] right_speed_o,
  output logic [1:0]                          drive_mode_o,
  output logic                                indicator_o,
  output logic                                white_line_track_o
);
  import lpps_pkg::*;

  // persistent state
  logic                    pol_q, pol_d;
  logic [1:0]              edge_q, edge_d;
  logic signed [ERR_W-1:0] sum_q;
  logic signed [ERR_W-1:0] last_q;
  logic [1:0]              rec_q;
  logic                    fls_q;
  logic                    out_valid_q;

  // per-sample working registers
  logic [SENSOR_WIDTH-1:0] line_q;
  logic                    ind_q;
  logic                    hold_q;
  logic                    cnt_zero_q;
  logic [CNT_W-1:0]        dvs_q;
  logic [WSUM_W-1:0]       dvd_q;
  logic [CNT_W-1:0]        rem_q;
  logic signed [ERR_W-1:0] err_q;
  logic signed [ERR_W:0]   d_q;
  logic signed [ACC_W-1:0] acc_q;

  // result register
  logic signed [ERR_W-1:0]   pe_q, pid_q;
  logic signed [SPEED_W-1:0] ls_q, rs_q;
  logic [1:0]                mode_q;
  logic                      ind_out_q, pol_out_q;

  // load: learn polarity, normalize pattern, weigh it
  logic [SENSOR_WIDTH-1:0] line_d;
  logic [WSUM_W-1:0]       wsum;
  logic [CNT_W-1:0]        cnt;

  always_comb begin
    pol_d = pol_q;
    if (is_white(sensor_bits_i)) pol_d = 1'b1;
    else if (is_black(sensor_bits_i)) pol_d = 1'b0;
    line_d = pol_d ? sensor_bits_i : ~sensor_bits_i;
    wsum = '0;
    cnt  = '0;
    for (int i = 0; i < SENSOR_WIDTH; i++) begin
      if (line_d[SENSOR_WIDTH-1-i]) begin
        wsum = wsum + WSUM_W'(2 * (i + 1));
        cnt  = cnt + CNT_W'(1);
      end
    end
  end

  // one restoring divide step
  logic [CNT_W:0] rem_shift;
  logic           q_bit;
  logic [CNT_W:0] rem_next;

  always_comb begin
    rem_shift = {rem_q, dvd_q[WSUM_W-1]};
    q_bit     = (rem_shift >= {1'b0, dvs_q});
    rem_next  = q_bit ? (rem_shift - {1'b0, dvs_q}) : rem_shift;
  end

  // error from quotient, edge memory and lost line
  logic signed [ERR_W-1:0] lost_pos, lost_neg, err_d;
  logic                    l_bit, r_bit;

  always_comb begin
    lost_pos = $signed({1'b0, cfg_i.lost_error});
    lost_neg = -lost_pos;
    l_bit    = line_q[SENSOR_WIDTH-1];
    r_bit    = line_q[0];
    edge_d   = (rec_q != MODE_FWD && cfg_i.gap_mode) ? EDGE_NONE : edge_q;
    if (l_bit != r_bit) edge_d = l_bit ? EDGE_LEFT : EDGE_RIGHT;
    if (cnt_zero_q) err_d = '0;
    else err_d = $signed({2'b00, dvd_q}) - ERR_W'(SENSOR_WIDTH + 1);
    if (line_q == '0) begin
      if (edge_d == EDGE_RIGHT) err_d = lost_pos;
      else if (edge_d == EDGE_LEFT) err_d = lost_neg;
    end
  end

  // clamped integral and difference
  logic signed [ERR_W:0]   sum_raw;
  logic signed [ERR_W-1:0] sum_d;
  logic signed [ERR_W:0]   d_d;

  always_comb begin
    sum_raw = {sum_q[ERR_W-1], sum_q} + {err_q[ERR_W-1], err_q};
    if (err_q == '0) sum_d = '0;
    else if (sum_raw > SUM_MAX) sum_d = ERR_W'(SUM_MAX);
    else if (sum_raw < SUM_MIN) sum_d = ERR_W'(SUM_MIN);
    else sum_d = sum_raw[ERR_W-1:0];
    d_d = {err_q[ERR_W-1], err_q} - {last_q[ERR_W-1], last_q};
  end

  // shared multiplier
  logic [7:0]                 mul_a;
  logic signed [ERR_W:0]      mul_b;
  logic signed [ERR_W+9:0]    prod;

  always_comb begin
    unique case (cmd_i.mul_sel)
      SEL_P: begin
        mul_a = cfg_i.gain_p;
        mul_b = {err_q[ERR_W-1], err_q};
      end
      SEL_I: begin
        mul_a = cfg_i.gain_i;
        mul_b = {sum_q[ERR_W-1], sum_q};
      end
      default: begin
        mul_a = cfg_i.gain_d;
        mul_b = d_q;
      end
    endcase
    prod = $signed({1'b0, mul_a}) * mul_b;
  end

  // commit: clamp PID, pick drive mode and speeds
  logic signed [ERR_W-1:0]   pid_c;
  logic signed [SPEED_W-1:0] base_s, loff_s, roff_s, pid_s;
  logic signed [SPEED_W-1:0] ls_turn, rs_turn;
  logic                      full_c, is_lost;
  logic signed [ERR_W-1:0]   pe_n, pid_n;
  logic signed [SPEED_W-1:0] ls_n, rs_n;
  logic [1:0]                mode_n, rec_n;
  logic                      fls_n;

  always_comb begin
    if (acc_q > PID_MAX) pid_c = ERR_W'(PID_MAX);
    else if (acc_q < PID_MIN) pid_c = ERR_W'(PID_MIN);
    else pid_c = acc_q[ERR_W-1:0];
    base_s  = $signed({2'b00, cfg_i.base_speed});
    loff_s  = $signed({2'b00, cfg_i.left_offset});
    roff_s  = $signed({2'b00, cfg_i.right_offset});
    pid_s   = {pid_c[ERR_W-1], pid_c};
    ls_turn = base_s - loff_s;
    rs_turn = base_s - roff_s;
    full_c  = (line_q == FULL_LINE);
    is_lost = (err_q == lost_pos) || (err_q == lost_neg);

    pe_n   = err_q;
    pid_n  = pid_c;
    ls_n   = base_s - pid_s - roff_s;
    rs_n   = base_s + pid_s - loff_s;
    mode_n = MODE_FWD;
    rec_n  = MODE_FWD;
    fls_n  = full_c;
    if (hold_q) begin
      pe_n   = last_q;
      pid_n  = '0;
      ls_n   = ls_turn;
      rs_n   = rs_turn;
      mode_n = rec_q;
      rec_n  = rec_q;
      fls_n  = 1'b0;
    end else if (full_c && fls_q) begin
      ls_n   = '0;
      rs_n   = '0;
      mode_n = MODE_STOP;
      fls_n  = 1'b1;
    end else if (is_lost) begin
      // the positive test wins when both match
      rec_n  = (err_q == lost_pos) ? MODE_CCW : MODE_CW;
      mode_n = rec_n;
      ls_n   = ls_turn;
      rs_n   = rs_turn;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pol_q       <= 1'b0;
      edge_q      <= EDGE_NONE;
      sum_q       <= '0;
      last_q      <= '0;
      rec_q       <= MODE_FWD;
      fls_q       <= 1'b0;
      out_valid_q <= 1'b0;
      hold_q      <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        pol_q  <= pol_d;
        hold_q <= (rec_q != MODE_FWD) && !is_online(line_d);
      end
      if (cmd_i.err_en) edge_q <= edge_d;
      if (cmd_i.sum_en) begin
        sum_q  <= sum_d;
        last_q <= err_q;
      end
      if (cmd_i.commit) begin
        rec_q <= rec_n;
        fls_q <= fls_n;
      end
      if (cmd_i.commit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // working and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      line_q     <= line_d;
      ind_q      <= ((line_d & MID_MASK) == MID_MASK);
      cnt_zero_q <= (cnt == '0);
      dvs_q      <= cnt;
      dvd_q      <= wsum;
      rem_q      <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_next[CNT_W-1:0];
      dvd_q <= {dvd_q[WSUM_W-2:0], q_bit};
    end
    if (cmd_i.err_en) err_q <= err_d;
    if (cmd_i.sum_en) d_q <= d_d;
    if (cmd_i.mul_en) begin
      if (cmd_i.mul_sel == SEL_P) acc_q <= ACC_W'(prod);
      else acc_q <= acc_q + ACC_W'(prod);
    end
    if (cmd_i.commit) begin
      pe_q      <= pe_n;
      pid_q     <= pid_n;
      ls_q      <= ls_n;
      rs_q      <= rs_n;
      mode_q    <= mode_n;
      ind_out_q <= ind_q;
      pol_out_q <= pol_q;
    end
  end

  assign sts_o.hold     = hold_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o        = out_valid_q;
  assign position_error_o   = pe_q;
  assign pid_output_o       = pid_q;
  assign left_speed_o       = ls_q;
  assign right_speed_o      = rs_q;
  assign drive_mode_o       = mode_q;
  assign indicator_o        = ind_out_q;
  assign white_line_track_o = pol_out_q;

endmodule

// File: rtl/line_position_pid_steering_core.sv
// Top level of the line position PID steering block.
//
//  channel    dir  handshake       payload
//  sample_i   in   valid / ready   sensor_bits
//  result_o   out  valid / ready   position_error, pid_output, left/right_speed,
//                                  drive_mode, indicator, white_line_track
//  cfg        in   cfg_we_i        cfg_idx_i, cfg_data_i
//
// One sample at a time: on the tracking path the accepted beat goes through 7 divider
// steps for the centroid, error, integral, three passes through the shared multiplier
// and commit; during a held recovery turn it goes from the divide state to commit.
// A new sample is taken once the previous one has moved into the result register.
// A stalled result holds the commit stage; reset clears all tracking state and
// loads the register defaults, with no clearing pass.
module line_position_pid_steering_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  lpps_in_if.sink                         sample_i,
  lpps_out_if.source                      result_o,
  input  logic                            cfg_we_i,
  input  logic [lpps_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lpps_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import lpps_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  lpps_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  lpps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .in_ready_o (sample_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lpps_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .sensor_bits_i      (sample_i.sensor_bits),
    .out_ready_i        (result_o.ready),
    .out_valid_o        (result_o.valid),
    .position_error_o   (result_o.position_error),
    .pid_output_o       (result_o.pid_output),
    .left_speed_o       (result_o.left_speed),
    .right_speed_o      (result_o.right_speed),
    .drive_mode_o       (result_o.drive_mode),
    .indicator_o        (result_o.indicator),
    .white_line_track_o (result_o.white_line_track)
  );

endmodule

// File: dv/lpps_steering_checker.sv
// Predicts the steering result of each sensor beat and compares it with the core's output.
`timescale 1ns / 100ps
module lpps_steering_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  lpps_in_if                              sample_i,
  lpps_out_if                             result_i,
  input  logic                            cfg_we_i,
  input  logic [lpps_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lpps_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              mismatch_count_o,
  output int                              pending_o
);
  import lpps_pkg::*;

  typedef struct packed {
    logic signed [ERR_W-1:0]   position_error;
    logic signed [ERR_W-1:0]   pid_output;
    logic signed [SPEED_W-1:0] left_speed;
    logic signed [SPEED_W-1:0] right_speed;
    logic [1:0]                drive_mode;
    logic                      indicator;
    logic                      white_line_track;
  } steer_t;

  cfg_t       tune;
  logic       white_track;
  logic [1:0] seen_edge;
  logic [1:0] turn_mode;
  int         err_sum;
  int         prev_err;
  logic       full_prev;
  steer_t     steer_q[$];
  int         mismatches = 0;

  function automatic steer_t predict_steer(input logic [SENSOR_WIDTH-1:0] raw);
    steer_t r;
    logic [SENSOR_WIDTH-1:0] line;
    int wsum;
    int cnt;
    int err;
    int pid;
    int base;
    int lost;
    // known single-line patterns teach the track polarity
    if (raw inside {8'h60, 8'h70, 8'h20, 8'h30, 8'h38, 8'h10, 8'h18,
                    8'h1C, 8'h08, 8'h0C, 8'h0E, 8'h04, 8'h06})
      white_track = 1'b1;
    else if (raw inside {8'h9F, 8'h8F, 8'hDF, 8'hCF, 8'hC7, 8'hEF, 8'hE7,
                         8'hE3, 8'hF7, 8'hF3, 8'hF1, 8'hFB, 8'hF9})
      white_track = 1'b0;
    line = white_track ? raw : ~raw;
    base = int'(tune.base_speed);
    lost = int'(tune.lost_error);
    r.indicator        = ((line & MID_MASK) == MID_MASK);
    r.white_line_track = white_track;

    if (turn_mode != MODE_FWD) begin
      if (!(line inside {8'h60, 8'h70, 8'h30, 8'h38, 8'h18, 8'h1C, 8'h0C, 8'h0E, 8'h06,
                         8'h9F, 8'h8F, 8'hCF, 8'hC7, 8'hE7, 8'hE3, 8'hF3, 8'hF1, 8'hF9})) begin
        // keep turning: hold the last error, no correction
        full_prev        = 1'b0;
        r.position_error = ERR_W'(prev_err);
        r.pid_output     = '0;
        r.left_speed     = SPEED_W'(base - int'(tune.left_offset));
        r.right_speed    = SPEED_W'(base - int'(tune.right_offset));
        r.drive_mode     = turn_mode;
        return r;
      end
      if (tune.gap_mode) seen_edge = EDGE_NONE;
    end
    turn_mode = MODE_FWD;

    wsum = 0;
    cnt  = 0;
    for (int i = 0; i < SENSOR_WIDTH; i++) begin
      if (line[SENSOR_WIDTH-1-i]) begin
        wsum += 2 * (i + 1);
        cnt++;
      end
    end
    err = (cnt != 0) ? wsum / cnt - (SENSOR_WIDTH + 1) : 0;

    if (line[SENSOR_WIDTH-1] != line[0]) seen_edge = line[SENSOR_WIDTH-1] ? EDGE_LEFT : EDGE_RIGHT;
    if (line == '0) begin
      if (seen_edge == EDGE_RIGHT) err = lost;
      else if (seen_edge == EDGE_LEFT) err = -lost;
    end

    if (err == 0) begin
      err_sum = 0;
    end else begin
      err_sum += err;
      if (err_sum > 200) err_sum = 200;
      else if (err_sum < -200) err_sum = -200;
    end
    pid = int'(tune.gain_p) * err + int'(tune.gain_i) * err_sum
        + int'(tune.gain_d) * (err - prev_err);
    if (pid > 150) pid = 150;
    else if (pid < -150) pid = -150;
    prev_err = err;

    r.position_error = ERR_W'(err);
    r.pid_output     = ERR_W'(pid);

    if (line == FULL_LINE && full_prev) begin
      r.left_speed  = '0;
      r.right_speed = '0;
      r.drive_mode  = MODE_STOP;
      return r;
    end
    full_prev = (line == FULL_LINE);

    if (err == lost || err == -lost) begin
      turn_mode     = (err == lost) ? MODE_CCW : MODE_CW;
      r.left_speed  = SPEED_W'(base - int'(tune.left_offset));
      r.right_speed = SPEED_W'(base - int'(tune.right_offset));
      r.drive_mode  = turn_mode;
      return r;
    end

    r.left_speed  = SPEED_W'(base - pid - int'(tune.right_offset));
    r.right_speed = SPEED_W'(base + pid - int'(tune.left_offset));
    r.drive_mode  = MODE_FWD;
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [15:0] want,
                             input logic signed [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    steer_t want;
    if (!rst_ni) begin
      tune        = '{8'd10, 8'd0, 8'd0, 8'd150, 8'd50, 8'd50, 8'd100, 1'b1};
      white_track = 1'b0;
      seen_edge   = EDGE_NONE;
      turn_mode   = MODE_FWD;
      err_sum     = 0;
      prev_err    = 0;
      full_prev   = 1'b0;
      steer_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_GAIN_P:       tune.gain_p       = cfg_data_i;
          REG_GAIN_I:       tune.gain_i       = cfg_data_i;
          REG_GAIN_D:       tune.gain_d       = cfg_data_i;
          REG_BASE_SPEED:   tune.base_speed   = cfg_data_i;
          REG_LEFT_OFFSET:  tune.left_offset  = cfg_data_i;
          REG_RIGHT_OFFSET: tune.right_offset = cfg_data_i;
          REG_LOST_ERROR:   tune.lost_error   = cfg_data_i;
          REG_GAP_MODE:     tune.gap_mode     = cfg_data_i[0];
          default: ;
        endcase
      end
      // retire the oldest prediction before queuing a new one
      if (result_i.valid && result_i.ready) begin
        if (steer_q.size() == 0) begin
          mismatches++;
          $display("%0t: steering beat with no prediction pending, position_error %0d",
                   $time, result_i.position_error);
        end else begin
          want = steer_q.pop_front();
          check_field("position_error", 16'(want.position_error),
                      16'(result_i.position_error));
          check_field("pid_output", 16'(want.pid_output), 16'(result_i.pid_output));
          check_field("left_speed", 16'(want.left_speed), 16'(result_i.left_speed));
          check_field("right_speed", 16'(want.right_speed), 16'(result_i.right_speed));
          check_field("drive_mode", 16'(want.drive_mode), 16'(result_i.drive_mode));
          check_field("indicator", 16'(want.indicator), 16'(result_i.indicator));
          check_field("white_line_track", 16'(want.white_line_track),
                      16'(result_i.white_line_track));
        end
      end
      if (sample_i.valid && sample_i.ready)
        steer_q.push_back(predict_steer(sample_i.sensor_bits));
      pending_o <= steer_q.size();
    end
    mismatch_count_o <= mismatches;
  end

endmodule

// File: dv/line_position_pid_steering_core_tb.sv
// Stimulus, handshake idling and verdict for the line position PID steering core.
`timescale 1ns / 100ps
module line_position_pid_steering_core_tb;
  import lpps_pkg::*;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  int                    mismatch_count;
  int                    pending;
  int                    sent;
  bit                    calm;
  logic                  track_white;

  // line-domain patterns: 1 means the sensor sees the line
  logic [7:0] teach_pats [13] = '{8'h60, 8'h70, 8'h20, 8'h30, 8'h38, 8'h10, 8'h18,
                                  8'h1C, 8'h08, 8'h0C, 8'h0E, 8'h04, 8'h06};
  logic [7:0] online_pats [9] = '{8'h60, 8'h70, 8'h30, 8'h38, 8'h18, 8'h1C, 8'h0C,
                                  8'h0E, 8'h06};
  logic [7:0] edge_pats [8]   = '{8'h80, 8'hC0, 8'hE0, 8'hF0, 8'h01, 8'h03, 8'h07, 8'h0F};
  // raw patterns for the opening run under reset settings
  logic [7:0] opening_seq [24] = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'hE7, 8'h7F, 8'hFF, 8'hAA,
                                   8'hE7, 8'hFF, 8'h18, 8'h01, 8'h00, 8'h00, 8'h0C, 8'h7E,
                                   8'hFF, 8'hFF, 8'h60, 8'h06, 8'h80, 8'hC3, 8'h81, 8'h9F};

  lpps_in_if  sample_if ();
  lpps_out_if result_if ();

  line_position_pid_steering_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_i   (sample_if),
    .result_o   (result_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  lpps_steering_checker u_chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .sample_i         (sample_if),
    .result_i         (result_if),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic cfg_t phase_settings(input int p);
    cfg_t s;
    s = '{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
          8'($urandom), 8'($urandom_range(8, 255)), 1'($urandom)};
    case (p)
      0: s = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1};
      1: s = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd8, 1'b0};
      2: s = '{8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'd8, 1'b1};
      3: begin
        s.base_speed   = 8'h00;
        s.left_offset  = 8'hFF;
        s.right_offset = 8'hFF;
        s.lost_error   = 8'hFF;
        s.gap_mode     = 1'b0;
      end
      default: begin
        // in half of these phases, pick gentle gains for the correction
        if ($urandom_range(1) == 0) begin
          s.gain_p = 8'($urandom_range(20));
          s.gain_i = 8'($urandom_range(3));
          s.gain_d = 8'($urandom_range(12));
        end
      end
    endcase
    return s;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic send_sample(input logic [7:0] bits);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_if.valid       <= 1'b1;
    sample_if.sensor_bits <= bits;
    for (int k = 0; k < 13; k++) begin
      if (bits == teach_pats[k]) track_white = 1'b1;
      if (bits == ~teach_pats[k]) track_white = 1'b0;
    end
    do @(posedge clk_i); while (!sample_if.ready);
    sent++;
  endtask

  task automatic send_line(input logic [7:0] line);
    send_sample(track_white ? line : ~line);
  endtask

  // drop valid and hold until every predicted result has been taken
  task automatic wait_drained();
    sample_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // result side: random stalls landing at any point of the core's work
  initial begin
    int gap;
    int hold;
    result_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        result_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      result_if.ready <= 1'b1;
      hold = $urandom_range(1, 24);
      do begin
        @(posedge clk_i);
        hold--;
      end while (!result_if.valid && hold > 0);
    end
  end

  initial begin
    int   pos;
    int   n;
    int   r;
    cfg_t s;
    rst_ni                <= 1'b0;
    cfg_we_i              <= 1'b0;
    cfg_idx_i             <= REG_GAIN_P;
    cfg_data_i            <= '0;
    sample_if.valid       <= 1'b0;
    sample_if.sensor_bits <= '0;
    track_white = 1'b0;
    calm        = 1'b0;
    sent        = 0;
    pos         = 6;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening_seq[i]) send_sample(opening_seq[i]);

    for (int p = 0; p < 8; p++) begin
      wait_drained();
      s = phase_settings(p);
      write_reg(REG_GAIN_P, s.gain_p);
      write_reg(REG_GAIN_I, s.gain_i);
      write_reg(REG_GAIN_D, s.gain_d);
      write_reg(REG_BASE_SPEED, s.base_speed);
      write_reg(REG_LEFT_OFFSET, s.left_offset);
      write_reg(REG_RIGHT_OFFSET, s.right_offset);
      write_reg(REG_LOST_ERROR, s.lost_error);
      write_reg(REG_GAP_MODE, {7'd0, s.gap_mode});
      cfg_we_i <= 1'b0;
      while (sent < 24 + (p + 1) * 155) begin
        calm = ($urandom_range(9) == 0);
        r = $urandom_range(99);
        if (r < 50) begin
          // follow the line as it drifts across the array
          n = $urandom_range(3, 12);
          repeat (n) begin
            pos = pos + int'($urandom_range(2)) - 1;
            if (pos < 0) pos = 0;
            if (pos > 12) pos = 12;
            if ($urandom_range(4) == 0) send_line(edge_pats[$urandom_range(7)]);
            else send_line(teach_pats[pos]);
          end
        end else if (r < 72) begin
          // run off one edge, search through noise, then find the line again
          send_line(edge_pats[$urandom_range(7)]);
          repeat ($urandom_range(1, 3)) send_line(8'h00);
          repeat ($urandom_range(3)) send_line(8'($urandom));
          send_line(online_pats[$urandom_range(8)]);
        end else if (r < 82) begin
          repeat ($urandom_range(1, 4)) send_line(8'hFF);
          if ($urandom_range(1) == 0) send_line(8'h7E);
        end else if (r < 90) begin
          // flip the track polarity
          n = $urandom_range(12);
          send_sample(track_white ? ~teach_pats[n] : teach_pats[n]);
        end else begin
          repeat ($urandom_range(1, 3)) send_sample(8'($urandom));
        end
      end
    end

    wait_drained();
    repeat (32) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
